@@ design/rdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  localparam int unsigned MAG_W      = 64;  // magnitude width
  localparam int unsigned DIG_W      = 8;   // digit / radix width
  localparam int unsigned MAX_DIGITS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned STEP_BITS  = 8;   // dividend bits retired per cycle
  localparam int unsigned STEPS      = MAG_W / STEP_BITS;
  localparam int unsigned STEP_CNT_W = $clog2(STEPS);

  // handshake between sequencer and divide unit
  typedef struct packed {
    logic start;
  } rdc_div_req_t;

  typedef struct packed {
    logic done;
  } rdc_div_rsp_t;

endpackage

`default_nettype wire

@@ design/rdc_div_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rdc_div_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rdc_pkg::rdc_div_req_t      req_i,
  input  wire logic [rdc_pkg::MAG_W-1:0]  dividend_i,
  input  wire logic [rdc_pkg::DIG_W-1:0]  divisor_i,
  output rdc_pkg::rdc_div_rsp_t           rsp_o,
  output logic      [rdc_pkg::MAG_W-1:0]  quotient_o,
  output logic      [rdc_pkg::DIG_W-1:0]  remainder_o
);

  import rdc_pkg::*;

  logic [MAG_W-1:0]      quo_q, quo_d;
  logic [DIG_W-1:0]      rem_q, rem_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  // restoring division, STEP_BITS bits of the dividend per cycle
  always_comb begin
    logic [DIG_W:0]     r;
    logic [STEP_BITS-1:0] qb;
    r  = {1'b0, rem_q};
    qb = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      r = {r[DIG_W-1:0], quo_q[MAG_W-1-i]};
      if (r >= {1'b0, divisor_i}) begin
        r = r - {1'b0, divisor_i};
        qb[STEP_BITS-1-i] = 1'b1;
      end
    end
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[MAG_W-STEP_BITS-1:0], qb};
      rem_d = r[DIG_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == STEP_CNT_W'(STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ design/radix_digit_converter_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat content
// s_axis    in   tdata[63:0] value (signed), tdata[71:64] radix
// m_axis    out  tdata[7:0] digit, tlast on the least significant digit
//
// One item of D digits is computed digit by digit in the shared divide unit (8
// dividend bits per cycle); then, per digit, the digit buffer is read and the
// beat is handed out. D is 1..64.
// s_axis_tready_o is high only while idle. A stalled output holds its beat.
// Reset clears the sequencer; the digit buffer needs no clearing.

module radix_digit_converter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,   // [63:0] value, [71:64] radix
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] digit
  output logic             m_axis_tlast_o
);

  import rdc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [DIG_W-1:0] base_q, base_d;
  logic [DIG_W-1:0] rd_data_q;
  logic [DIG_W-1:0] digit_mem [MAX_DIGITS];

  logic             in_acc;
  logic [MAG_W-1:0] in_val;
  logic [DIG_W-1:0] in_radix;
  logic [MAG_W-1:0] mag;
  logic [MAG_W-1:0] div_dividend;
  logic [DIG_W-1:0] div_divisor;
  logic [MAG_W-1:0] div_quo;
  logic [DIG_W-1:0] div_rem;
  logic             more;
  rdc_div_req_t     div_req;
  rdc_div_rsp_t     div_rsp;

  assign in_val   = s_axis_tdata_i[MAG_W-1:0];
  assign in_radix = s_axis_tdata_i[MAG_W+DIG_W-1:MAG_W];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  // two's complement magnitude, taken unsigned so the most negative value works
  assign mag      = in_val[MAG_W-1] ? (~in_val + 1'b1) : in_val;

  // another digit follows while the quotient is nonzero and the buffer has room
  assign more = (div_quo != '0) && (n_q != CNT_W'(MAX_DIGITS - 1));

  assign div_req.start = in_acc || (state_q == S_DIV && div_rsp.done && more);
  assign div_dividend  = in_acc ? mag : div_quo;
  assign div_divisor   = in_acc ? base_d : base_q;

  rdc_div_unit u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .rsp_o       (div_rsp),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    rd_idx_d = rd_idx_q;
    base_d   = base_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          base_d  = (in_radix < DIG_W'(2)) ? DIG_W'(2) : in_radix;
          n_d     = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          n_d = n_q + 1'b1;
          if (!more) begin
            rd_idx_d = n_q[IDX_W-1:0];
            state_d  = S_RD;
          end
        end
      end
      S_RD: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready_i) begin
          if (rd_idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - 1'b1;
            state_d  = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      n_q      <= '0;
      rd_idx_q <= '0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
  end

  // digit buffer, least significant digit at entry 0
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV && div_rsp.done) begin
      digit_mem[n_q[IDX_W-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_data_q <= digit_mem[rd_idx_q];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = rd_data_q;
  assign m_axis_tlast_o  = (rd_idx_q == '0);

endmodule

`default_nettype wire

@@ sim/radix_digit_converter_top_tb.sv @@
`timescale 1ns / 1ps

class digit_scoreboard;

  typedef struct {
    logic [7:0] digit;
    logic       last;
  } digit_beat_t;

  digit_beat_t expected_digits[$];
  int          numbers_seen;
  int          digits_checked;
  int          mismatches;
  int          longest_run;
  int          low_radix_runs;

  function new();
    numbers_seen   = 0;
    digits_checked = 0;
    mismatches     = 0;
    longest_run    = 0;
    low_radix_runs = 0;
  endfunction

  // Splits |value| into digits of the effective base, queues them MSD first.
  function void note_input(logic [63:0] value, logic [7:0] radix);
    logic [63:0] magnitude;
    logic [63:0] base;
    logic [7:0]  scratch [64];
    int          n;
    digit_beat_t b;
    magnitude = value[63] ? (~value + 64'd1) : value;
    base      = (radix < 8'd2) ? 64'd2 : {56'd0, radix};
    if (radix < 8'd2) low_radix_runs++;
    n = 0;
    do begin
      scratch[n] = 8'((magnitude % base) & 64'hFF);
      magnitude  = magnitude / base;
      n++;
    end while (magnitude != 64'd0 && n < 64);
    for (int k = 0; k < n; k++) begin
      b.digit = scratch[n - 1 - k];
      b.last  = (k == n - 1);
      expected_digits.push_back(b);
    end
    if (n > longest_run) longest_run = n;
    numbers_seen++;
  endfunction

  function void report_mismatch(string what, logic [7:0] exp_d, logic exp_l,
                                logic [7:0] got_d, logic got_l);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: expected digit %0d last %0b, got digit %0d last %0b",
               $realtime, what, exp_d, exp_l, got_d, got_l);
  endfunction

  function void check_digit(logic [7:0] got_d, logic got_l);
    digit_beat_t e;
    if (expected_digits.size() == 0) begin
      report_mismatch("digit beat with nothing pending", 8'd0, 1'b0, got_d, got_l);
      return;
    end
    e = expected_digits.pop_front();
    digits_checked++;
    if (got_d !== e.digit || got_l !== e.last)
      report_mismatch("digit beat mismatch", e.digit, e.last, got_d, got_l);
  endfunction

  function int pending();
    return expected_digits.size();
  endfunction

endclass

module radix_digit_converter_top_tb;

  localparam int RANDOM_NUMBERS = 450;
  localparam int CALM_AFTER     = 390;   // no idling from here on
  localparam int STALL_LIMIT    = 4000;  // cycles without any beat
  localparam int DRAIN_CYCLES   = 40;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic [71:0] s_axis_tdata_i  = '0;   // [63:0] value, [71:64] radix
  logic        m_axis_tready_i = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;        // [7:0] digit
  logic        m_axis_tlast_o;

  digit_scoreboard sb = new();
  bit calm        = 1'b0;
  int stall_left  = 0;
  int idle_cycles = 0;

  radix_digit_converter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // output side backpressure
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= $urandom_range(1, 5) - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_digit(m_axis_tdata_o, m_axis_tlast_o);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d digits pending",
                 idle_cycles, sb.pending());
        $display("radix_digit_converter_top_tb: errors");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic push_number(logic [63:0] value, logic [7:0] radix);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {radix, value};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(value, radix);
    @(negedge clk_i);
  endtask

  initial begin
    logic [63:0] v;
    logic [63:0] p;
    logic [7:0]  r;
    int          k;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: zero, sign handling, extremes, radix edges
    push_number(64'd0, 8'd10);
    push_number(64'd1, 8'd10);
    push_number(-64'sd1, 8'd10);
    push_number(64'd9, 8'd10);
    push_number(64'd10, 8'd10);
    push_number(-64'sd10, 8'd10);
    push_number(64'h7FFF_FFFF_FFFF_FFFF, 8'd2);
    push_number(64'h8000_0000_0000_0000, 8'd2);   // magnitude 2^63
    push_number(64'h8000_0000_0000_0000, 8'd10);
    push_number(64'h8000_0000_0000_0000, 8'd16);
    push_number(64'h8000_0000_0000_0000, 8'd255);
    push_number(64'h8000_0000_0000_0000, 8'd0);
    push_number(64'h8000_0000_0000_0001, 8'd3);
    push_number(64'h7FFF_FFFF_FFFF_FFFF, 8'd255);
    push_number(64'd254, 8'd255);
    push_number(64'd255, 8'd255);
    push_number(-64'sd1, 8'd255);
    push_number(64'd5, 8'd0);                     // bases below two act as two
    push_number(64'd5, 8'd1);
    push_number(64'd0, 8'd0);
    push_number(64'd123456789, 8'd7);
    push_number(64'h0123_4567_89AB_CDEF, 8'd16);

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      if (i >= CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 9))
        0:       r = 8'($urandom_range(0, 1));
        1:       r = 8'd2;
        2:       r = 8'd10;
        3:       r = 8'd16;
        4:       r = 8'd255;
        default: r = 8'($urandom_range(2, 255));
      endcase
      case ($urandom_range(0, 7))
        0, 1: v = {$urandom, $urandom};
        2:    v = 64'($urandom_range(0, 300));
        3:    v = {32'd0, $urandom};
        4: begin
          // around a power of the base, where the digit count steps
          p = 64'd1;
          k = $urandom_range(1, 8);
          repeat (k) p = p * ((r < 8'd2) ? 64'd2 : {56'd0, r});
          v = p + 64'($urandom_range(0, 2)) - 64'd1;
        end
        5: begin
          case ($urandom_range(0, 3))
            0:       v = 64'h8000_0000_0000_0000;
            1:       v = 64'h7FFF_FFFF_FFFF_FFFF;
            2:       v = 64'hFFFF_FFFF_FFFF_FFFF;
            default: v = 64'd0;
          endcase
        end
        default: v = 64'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
      push_number(v, r);
    end
    s_axis_tvalid_i = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("converted %0d numbers into %0d digit beats, longest run %0d digits",
             sb.numbers_seen, sb.digits_checked, sb.longest_run);
    $display("%0d numbers used a base below two; %0d mismatches",
             sb.low_radix_runs, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("radix_digit_converter_top_tb: clean");
    end else begin
      $display("radix_digit_converter_top_tb: errors");
    end
    $finish;
  end

endmodule
